[rtl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared widths, codes and controller/datapath interface types for the
// round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

   // default table size
   localparam int DEF_SLOTS = 8;

   // field widths
   localparam int ACTION_W = 3;
   localparam int TID_W    = 16;
   localparam int RSLOT_W  = 3;
   localparam int STATE_W  = 3;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_CREATE  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_BLOCK   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_UNBLOCK = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_YIELD   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_EXIT    = 3'd4;

   // slot state codes
   localparam logic [STATE_W-1:0] SS_EMPTY      = 3'd0;
   localparam logic [STATE_W-1:0] SS_READY      = 3'd1;
   localparam logic [STATE_W-1:0] SS_RUNNING    = 3'd2;
   localparam logic [STATE_W-1:0] SS_BLOCKED    = 3'd3;
   localparam logic [STATE_W-1:0] SS_TERMINATED = 3'd4;

   // controller states
   typedef enum logic [2:0] {
      CS_IDLE,
      CS_CUR_RD,
      CS_CUR_WR,
      CS_SCAN,
      CS_RES_RD,
      CS_RESP
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // latch request fields, clear result
      logic scan_init;  // restart the slot scan
      logic scan_wrap;  // scan starts after the current slot
      logic scan_step;  // issue next scan read
      logic read_cur;   // read the current slot
      logic hit_write;  // apply the action to the matched slot
      logic cur_write;  // retire the current thread before scheduling
      logic set_full;   // create found no empty slot
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                hit;        // scanned slot matches
      logic                exhausted;  // every slot scanned, none matched
   } dp_stat_type;

endpackage

[rtl/round_robin_thread_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_unit
// Thread slot table with create, block, unblock, yield and exit actions and a
// round-robin scheduler, built as a sequencer and a slot-table datapath.
//
//   channel   handshake              payload
//   request   start / busy           req_action, req_thread_id
//   response  rsp_strobe (1 cycle)   rsp_status, rsp_new_thread_id,
//                                    rsp_running_slot, rsp_running_id, rsp_idle
//
// One transaction at a time; busy is high from acceptance until the response.
// The slot scan reads one table entry per cycle through a single read port;
// create, block and unblock scan the table directly, yield and exit first
// retire the current slot, and other actions skip the scan.
// After reset the table reads slot 0 running and the rest empty at once.
// The response is shown for one cycle and is never held back.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_unit #(
   parameter int SLOTS = rrts_pkg::DEF_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rrts_pkg::ACTION_W-1:0] req_action,
   input  logic [rrts_pkg::TID_W-1:0]    req_thread_id,
   output logic                          rsp_strobe,
   output logic                          rsp_status,
   output logic [rrts_pkg::TID_W-1:0]    rsp_new_thread_id,
   output logic [rrts_pkg::RSLOT_W-1:0]  rsp_running_slot,
   output logic [rrts_pkg::TID_W-1:0]    rsp_running_id,
   output logic                          rsp_idle
);
   import rrts_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   rrts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   // slot table and scan datapath
   rrts_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_thread_id     (req_thread_id),
      .rsp_status        (rsp_status),
      .rsp_new_thread_id (rsp_new_thread_id),
      .rsp_running_slot  (rsp_running_slot),
      .rsp_running_id    (rsp_running_id),
      .rsp_idle          (rsp_idle)
   );

endmodule

[rtl/rrts_ctrl.sv]
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer for the scheduler: steps a transaction through current slot
// retire (yield/exit), slot scan/write-back (valid actions), result read.
// ----------------------------------------------------------------------------
module rrts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   input  rrts_pkg::dp_stat_type stat,
   output rrts_pkg::dp_cmd_type  cmd
);
   import rrts_pkg::*;

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (stat.action == ACT_CREATE || stat.action == ACT_BLOCK ||
                   stat.action == ACT_UNBLOCK) begin
                  cmd.scan_init = 1'b1;
                  state_in      = CS_SCAN;
               end else if (stat.action == ACT_YIELD || stat.action == ACT_EXIT) begin
                  state_in = CS_CUR_RD;
               end else begin
                  state_in = CS_RES_RD;
               end
            end
         end
         CS_CUR_RD: begin
            cmd.read_cur = 1'b1;
            state_in     = CS_CUR_WR;
         end
         CS_CUR_WR: begin
            cmd.cur_write = 1'b1;
            cmd.scan_init = 1'b1;
            cmd.scan_wrap = 1'b1;
            state_in      = CS_SCAN;
         end
         CS_SCAN: begin
            if (stat.hit) begin
               cmd.hit_write = 1'b1;
               state_in      = CS_RES_RD;
            end else if (stat.exhausted) begin
               cmd.set_full = (stat.action == ACT_CREATE);
               state_in     = CS_RES_RD;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         CS_RES_RD: begin
            cmd.read_cur = 1'b1;
            state_in     = CS_RESP;
         end
         CS_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

[rtl/rrts_datapath.sv]
// ----------------------------------------------------------------------------
// rrts_datapath
// Slot table memory with registered read, scan address generation, match
// logic, current slot, id counter and running-thread count.
// ----------------------------------------------------------------------------
module rrts_datapath #(
   parameter int SLOTS = rrts_pkg::DEF_SLOTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rrts_pkg::dp_cmd_type           cmd,
   output rrts_pkg::dp_stat_type          stat,
   input  logic [rrts_pkg::ACTION_W-1:0]  req_action,
   input  logic [rrts_pkg::TID_W-1:0]     req_thread_id,
   output logic                           rsp_status,
   output logic [rrts_pkg::TID_W-1:0]     rsp_new_thread_id,
   output logic [rrts_pkg::RSLOT_W-1:0]   rsp_running_slot,
   output logic [rrts_pkg::TID_W-1:0]     rsp_running_id,
   output logic                           rsp_idle
);
   import rrts_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam logic [SLOT_W:0]   SLOTS_EXT = (SLOT_W + 1)'(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [TID_W-1:0]   id;
   } slot_entry_type;

   // slot table, entries read as reset value until first written
   slot_entry_type mem [SLOTS];
   logic [SLOTS-1:0] valid_ff, valid_in;

   logic [ACTION_W-1:0] action_ff, action_in;
   logic [TID_W-1:0]    tid_ff, tid_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [TID_W-1:0]    next_id_ff, next_id_in;
   logic                status_ff, status_in;
   logic [TID_W-1:0]    new_id_ff, new_id_in;
   logic [CNT_W-1:0]    run_cnt_ff, run_cnt_in;
   logic [SLOT_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rd_live_ff, rd_live_in;
   logic [STATE_W-1:0]  rd_state_ff;
   logic [TID_W-1:0]    rd_id_ff;
   logic [SLOT_W-1:0]   rd_idx_ff;

   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   logic [STATE_W-1:0]  wr_state;
   logic [TID_W-1:0]    wr_id;
   logic                sched;
   logic                match;
   logic                scan_more;
   logic [SLOT_W:0]     scan_sum;
   logic [SLOT_W-1:0]   scan_addr;
   logic [SLOT_W-1:0]   cur_plus;
   logic [SLOT_W+RSLOT_W-1:0] cur_wide;

   // scan address: base plus offset, wrapped once
   assign scan_sum  = {1'b0, base_ff} + {1'b0, cnt_ff[SLOT_W-1:0]};
   assign scan_addr = (scan_sum >= SLOTS_EXT) ? SLOT_W'(scan_sum - SLOTS_EXT)
                                              : scan_sum[SLOT_W-1:0];
   assign scan_more = (cnt_ff != CNT_W'(SLOTS));
   assign cur_plus  = (cur_ff == LAST_SLOT) ? '0 : cur_ff + 1'b1;
   assign sched     = (action_ff == ACT_YIELD) || (action_ff == ACT_EXIT);

   // match condition for the entry just read
   always_comb begin
      unique case (action_ff)
         ACT_CREATE:  match = (rd_state_ff == SS_EMPTY);
         ACT_BLOCK,
         ACT_UNBLOCK: match = (rd_state_ff != SS_EMPTY) && (rd_id_ff == tid_ff);
         ACT_YIELD,
         ACT_EXIT:    match = (rd_state_ff == SS_READY);
         default:     match = 1'b0;
      endcase
   end

   assign stat.action    = cmd.load ? req_action : action_ff;
   assign stat.hit       = rd_live_ff && match;
   assign stat.exhausted = !rd_live_ff && !scan_more;

   // command decode and next values
   always_comb begin
      action_in  = action_ff;
      tid_in     = tid_ff;
      cur_in     = cur_ff;
      next_id_in = next_id_ff;
      status_in  = status_ff;
      new_id_in  = new_id_ff;
      base_in    = base_ff;
      cnt_in     = cnt_ff;
      rd_live_in = rd_live_ff;
      valid_in   = valid_ff;
      rd_en      = 1'b0;
      rd_addr    = scan_addr;
      wr_en      = 1'b0;
      wr_addr    = rd_idx_ff;
      wr_state   = rd_state_ff;
      wr_id      = rd_id_ff;

      if (cmd.load) begin
         action_in = req_action;
         tid_in    = req_thread_id;
         status_in = 1'b0;
         new_id_in = '0;
      end
      if (cmd.scan_init) begin
         cnt_in     = '0;
         rd_live_in = 1'b0;
         base_in    = cmd.scan_wrap ? cur_plus : '0;
      end
      if (cmd.scan_step) begin
         rd_en      = scan_more;
         rd_live_in = scan_more;
         if (scan_more) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
      if (cmd.read_cur) begin
         rd_en      = 1'b1;
         rd_addr    = cur_ff;
         rd_live_in = 1'b0;
      end
      // action on the matched slot
      if (cmd.hit_write) begin
         unique case (action_ff)
            ACT_CREATE: begin
               wr_en      = 1'b1;
               wr_state   = SS_READY;
               wr_id      = next_id_ff;
               new_id_in  = next_id_ff;
               next_id_in = next_id_ff + 1'b1;
            end
            ACT_BLOCK: begin
               wr_en    = 1'b1;
               wr_state = SS_BLOCKED;
            end
            ACT_UNBLOCK: begin
               wr_en    = (rd_state_ff == SS_BLOCKED);
               wr_state = SS_READY;
            end
            ACT_YIELD, ACT_EXIT: begin
               wr_en    = 1'b1;
               wr_state = SS_RUNNING;
               cur_in   = rd_idx_ff;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
      // retire current thread before the round-robin search
      if (cmd.cur_write) begin
         if (action_ff == ACT_EXIT) begin
            wr_en    = (rd_state_ff != SS_EMPTY);
            wr_state = SS_TERMINATED;
         end else begin
            wr_en    = (rd_state_ff == SS_RUNNING);
            wr_state = SS_READY;
         end
      end
      if (cmd.set_full) begin
         status_in = 1'b1;
      end
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // running-thread count follows every write into or out of the running state
   always_comb begin
      run_cnt_in = run_cnt_ff;
      if (wr_en && (rd_state_ff == SS_RUNNING) && (wr_state != SS_RUNNING)) begin
         run_cnt_in = run_cnt_ff - 1'b1;
      end else if (wr_en && (rd_state_ff != SS_RUNNING) && (wr_state == SS_RUNNING)) begin
         run_cnt_in = run_cnt_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff     <= '0;
         next_id_ff <= TID_W'(1);
         run_cnt_ff <= CNT_W'(1);
         valid_ff   <= '0;
         rd_live_ff <= 1'b0;
         cnt_ff     <= '0;
         base_ff    <= '0;
      end else begin
         cur_ff     <= cur_in;
         next_id_ff <= next_id_in;
         run_cnt_ff <= run_cnt_in;
         valid_ff   <= valid_in;
         rd_live_ff <= rd_live_in;
         cnt_ff     <= cnt_in;
         base_ff    <= base_in;
      end
   end

   // transaction payload registers
   always_ff @(posedge clock) begin
      action_ff <= action_in;
      tid_ff    <= tid_in;
      status_ff <= status_in;
      new_id_ff <= new_id_in;
   end

   // slot table write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= '{state: wr_state, id: wr_id};
      end
      if (rd_en) begin
         rd_idx_ff <= rd_addr;
         if (valid_ff[rd_addr]) begin
            rd_state_ff <= mem[rd_addr].state;
            rd_id_ff    <= mem[rd_addr].id;
         end else begin
            rd_state_ff <= (rd_addr == '0) ? SS_RUNNING : SS_EMPTY;
            rd_id_ff    <= '0;
         end
      end
   end

   // result fields
   assign cur_wide          = {{RSLOT_W{1'b0}}, cur_ff};
   assign rsp_status        = status_ff;
   assign rsp_new_thread_id = new_id_ff;
   assign rsp_running_slot  = cur_wide[RSLOT_W-1:0];
   assign rsp_running_id    = rd_id_ff;
   assign rsp_idle          = (run_cnt_ff == '0);

endmodule
